/* hdl/software_timer_table_defines.svh */
// assertion helpers for the timer table
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer table check failed");

// consequent holds in the cycle after the antecedent
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer table check failed");

`endif

/* hdl/stt_pkg.sv */
package stt_pkg;

    // field widths
    localparam int TASK_W    = 16;
    localparam int TIMER_W   = 16;
    localparam int TIME_W    = 32;
    localparam int PAYLOAD_W = 32;
    localparam int TIMEOUT_W = 27;

    // stream widths
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;

    // timeout limits
    localparam logic [TIMEOUT_W-1:0] MAX_TIMEOUT_MS = 27'd86400000;
    localparam logic [TIMEOUT_W-1:0] MIN_TIMEOUT_MS = 27'd10;

    // request commands
    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // result kinds
    localparam logic [1:0] RK_SET_REPLY   = 2'd0;
    localparam logic [1:0] RK_CLEAR_REPLY = 2'd1;
    localparam logic [1:0] RK_EXPIRY      = 2'd2;
    localparam logic [1:0] RK_DONE        = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ID    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // slot write kinds
    localparam logic [1:0] WR_ZERO   = 2'd0;
    localparam logic [1:0] WR_SET    = 2'd1;
    localparam logic [1:0] WR_FREE   = 2'd2;
    localparam logic [1:0] WR_EXPIRE = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       addr_zero;
        logic       addr_inc;
        logic       wr_en;
        logic [1:0] wr_kind;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] emit_status;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_ready;
        logic last_slot;
        logic bad_id;
        logic slot_free;
        logic slot_match;
        logic slot_expired;
    } t_dp_stat;

endpackage

/* hdl/stt_ctrl.sv */
module stt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic [1:0]        i_command,
    output logic              o_s_tready,
    input  stt_pkg::t_dp_stat i_stat,
    output stt_pkg::t_dp_cmd  o_cmd
);
    import stt_pkg::*;

    localparam logic [2:0] S_WIPE = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SET  = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_WIPE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_kind = WR_ZERO;
                if (i_stat.last_slot) begin
                    o_cmd.addr_zero = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.addr_zero = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_command)
                        CMD_SET:   n_state = S_SET;
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_CHECK: n_state = S_CHK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SET: begin
                o_cmd.emit_kind = RK_SET_REPLY;
                if (i_stat.bad_id) begin
                    if (i_stat.out_ready) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_BAD_ID;
                        o_cmd.addr_zero   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.slot_free) begin
                    if (i_stat.out_ready) begin
                        o_cmd.wr_en       = 1'b1;
                        o_cmd.wr_kind     = WR_SET;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_OK;
                        o_cmd.addr_zero   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.last_slot) begin
                    if (i_stat.out_ready) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_FULL;
                        o_cmd.addr_zero   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_CLR: begin
                o_cmd.emit_kind = RK_CLEAR_REPLY;
                if (i_stat.slot_match) begin
                    if (i_stat.out_ready) begin
                        o_cmd.wr_en       = 1'b1;
                        o_cmd.wr_kind     = WR_FREE;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_OK;
                        o_cmd.addr_zero   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.last_slot) begin
                    if (i_stat.out_ready) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_NOT_FOUND;
                        o_cmd.addr_zero   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.addr_inc = 1'b1;
                end
            end
            S_CHK: begin
                o_cmd.emit_kind   = RK_EXPIRY;
                o_cmd.emit_status = ST_OK;
                // an expired slot waits for room in the output register
                if (!i_stat.slot_expired || i_stat.out_ready) begin
                    if (i_stat.slot_expired) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_kind = WR_EXPIRE;
                        o_cmd.emit    = 1'b1;
                    end
                    if (i_stat.last_slot) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.addr_inc = 1'b1;
                    end
                end
            end
            S_DONE: begin
                o_cmd.emit_kind   = RK_DONE;
                o_cmd.emit_status = ST_OK;
                o_cmd.addr_zero   = 1'b1;
                if (i_stat.out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_WIPE;
            end
        endcase
    end

endmodule

/* hdl/stt_dp.sv */
module stt_dp #(
    parameter int SLOTS     = 32,
    parameter int TIMER_IDS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [stt_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic [stt_pkg::S_TUSER_W-1:0]    i_s_tuser,
    input  stt_pkg::t_dp_cmd                 i_cmd,
    output stt_pkg::t_dp_stat                o_stat,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [stt_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic [stt_pkg::M_TUSER_W-1:0]    o_m_tuser,
    output logic                             o_m_tlast
);
    import stt_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = (TIMER_IDS > 1) ? $clog2(TIMER_IDS) : 1;

    typedef struct packed {
        logic                 valid;
        logic                 periodic;
        logic [TASK_W-1:0]    owner;
        logic [TW-1:0]        timer_id;
        logic [TIMEOUT_W-1:0] timeout;
        logic [TIME_W-1:0]    start;
        logic                 pkind;
        logic [PAYLOAD_W-1:0] payload;
    } t_slot;

    // latched request
    logic                 r_periodic;
    logic [TASK_W-1:0]    r_owner;
    logic [TIMER_W-1:0]   r_timer;
    logic [TIME_W-1:0]    r_timeout;
    logic                 r_pkind;
    logic [PAYLOAD_W-1:0] r_pval;
    logic [TIME_W-1:0]    r_now;

    // slot memory and scan pointer
    t_slot                r_mem [SLOTS];
    t_slot                r_rd;
    t_slot                w_wr_word;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        n_addr;

    logic [TIMEOUT_W-1:0] w_timeout;
    logic [TIME_W-1:0]    w_elapsed;
    logic                 w_is_expiry;

    // output register
    logic                 r_m_valid;
    logic [1:0]           r_kind;
    logic [1:0]           r_status;
    logic [TASK_W-1:0]    r_owner_res;
    logic [TIMER_W-1:0]   r_timer_res;
    logic                 r_pkind_res;
    logic [PAYLOAD_W-1:0] r_pval_res;
    logic                 r_last;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_periodic <= i_s_tdata[0];
            r_owner    <= i_s_tdata[16:1];
            r_timer    <= i_s_tdata[32:17];
            r_timeout  <= i_s_tdata[64:33];
            r_pval     <= i_s_tdata[96:65];
            r_now      <= i_s_tdata[128:97];
            r_pkind    <= i_s_tuser[2];
        end
    end

    // timeout clamp: zero goes up to the minimum, long ones down to one day
    always_comb begin
        if (r_timeout == '0) begin
            w_timeout = MIN_TIMEOUT_MS;
        end else if (r_timeout > {{(TIME_W-TIMEOUT_W){1'b0}}, MAX_TIMEOUT_MS}) begin
            w_timeout = MAX_TIMEOUT_MS;
        end else begin
            w_timeout = r_timeout[TIMEOUT_W-1:0];
        end
    end

    // scan pointer
    always_comb begin
        if (i_cmd.addr_zero) begin
            n_addr = '0;
        end else if (i_cmd.addr_inc) begin
            n_addr = AW'(r_addr + 1'b1);
        end else begin
            n_addr = r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            r_addr <= n_addr;
        end
    end

    // slot write word
    always_comb begin
        w_wr_word = r_rd;
        case (i_cmd.wr_kind)
            WR_ZERO: begin
                w_wr_word = '0;
            end
            WR_SET: begin
                w_wr_word.valid    = 1'b1;
                w_wr_word.periodic = r_periodic;
                w_wr_word.owner    = r_owner;
                w_wr_word.timer_id = r_timer[TW-1:0];
                w_wr_word.timeout  = w_timeout;
                w_wr_word.start    = r_now;
                w_wr_word.pkind    = r_pkind;
                w_wr_word.payload  = r_pval;
            end
            WR_FREE: begin
                w_wr_word.valid = 1'b0;
            end
            default: begin
                // expiry: periodic restarts, one-shot is freed
                if (r_rd.periodic) begin
                    w_wr_word.start = r_now;
                end else begin
                    w_wr_word.valid = 1'b0;
                end
            end
        endcase
    end

    // memory: one write, one registered read at the next pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_addr] <= w_wr_word;
        end
        r_rd <= r_mem[n_addr];
    end

    // slot status
    assign w_elapsed = r_now - r_rd.start;

    always_comb begin
        o_stat.out_ready    = !r_m_valid || i_m_tready;
        o_stat.last_slot    = (r_addr == AW'(SLOTS - 1));
        o_stat.bad_id       = (r_timer >= TIMER_W'(TIMER_IDS));
        o_stat.slot_free    = !r_rd.valid;
        o_stat.slot_match   = r_rd.valid && (r_rd.owner == r_owner)
                              && (TIMER_W'(r_rd.timer_id) == r_timer);
        o_stat.slot_expired = r_rd.valid
                              && (w_elapsed >= {{(TIME_W-TIMEOUT_W){1'b0}}, r_rd.timeout});
    end

    assign w_is_expiry = (i_cmd.emit_kind == RK_EXPIRY);

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind      <= i_cmd.emit_kind;
            r_status    <= i_cmd.emit_status;
            r_owner_res <= w_is_expiry ? r_rd.owner : r_owner;
            r_timer_res <= w_is_expiry ? TIMER_W'(r_rd.timer_id) : r_timer;
            r_pkind_res <= w_is_expiry ? r_rd.pkind : 1'b0;
            r_pval_res  <= w_is_expiry ? r_rd.payload : '0;
            r_last      <= !w_is_expiry;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_pval_res, r_timer_res, r_owner_res, r_status};
    assign o_m_tuser  = {r_pkind_res, r_kind};
    assign o_m_tlast  = r_last;

endmodule

/* hdl/software_timer_table.sv */
// Timer table with one-shot and periodic timers.
// Requests enter on the slave stream: tuser carries the command and the
// payload kind, tdata the timer fields and the current time in ms. Results
// leave on the master stream: set and clear replies, one expiry per expired
// timer during a check, then a check-done result; tlast marks the final
// result of each request. A request with the unused command gives nothing.
// Set, clear and check requests each make a linear walk over the slot
// memory through its single read port, one slot a cycle while no result
// waits for the output register. A set stops at the first free slot and
// a clear at the first matching one, else both at the last slot; a set
// with a bad timer id needs no walk, and a check visits all. A request is
// taken only while no other is in work; a finished result waits in an
// output register so the next request may be accepted before it is taken.
// When the receiver stalls, the walk holds on the slot that has a result
// to give and resumes once the output register frees up.
// After reset the slot memory is cleared in one pass over all slots, with
// tready low; all timers are then free.
`include "software_timer_table_defines.svh"

module software_timer_table #(
    parameter int SLOTS     = 32,
    parameter int TIMER_IDS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave request channel
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: periodic, owner_task, timer_number, timeout_ms, payload_value, now_ms
    input  logic [stt_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: command, payload_kind
    input  logic [stt_pkg::S_TUSER_W-1:0] i_s_tuser,
    // master result channel
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: status, owner_task_res, timer_number_res, payload_value_res
    output logic [stt_pkg::M_TDATA_W-1:0] o_m_tdata,
    // tuser: result_kind, payload_kind_res
    output logic [stt_pkg::M_TUSER_W-1:0] o_m_tuser,
    output logic                          o_m_tlast
);
    import stt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_command  (i_s_tuser[1:0]),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // slot memory and result path
    stt_dp #(
        .SLOTS     (SLOTS),
        .TIMER_IDS (TIMER_IDS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // a real request closes the slave side until it is done
    `STT_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tuser[1:0] != CMD_NONE), !o_s_tready)

    // only expiries continue a result run
    `STT_ASSERT_SAME(a_last_marks_end, i_clk, i_rst_n, o_m_tvalid, o_m_tlast == (o_m_tuser[1:0] != RK_EXPIRY))

    // expiries always carry ok status
    `STT_ASSERT_SAME(a_expiry_status_ok, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser[1:0] == RK_EXPIRY), o_m_tdata[1:0] == ST_OK)

endmodule

/* dv/software_timer_table_test.sv */
module software_timer_table_test;

    import stt_pkg::*;

    localparam int SLOTS           = 32;
    localparam int TIMER_IDS       = 32;
    localparam int REQUEST_TARGET  = 370;
    localparam int CALM_TAIL       = 50;
    localparam int STALL_LIMIT     = 4000;

    // one request as it goes into the table
    typedef struct packed {
        logic [1:0]           command;
        logic                 periodic;
        logic [TASK_W-1:0]    owner;
        logic [TIMER_W-1:0]   timer_id;
        logic [TIME_W-1:0]    timeout_ms;
        logic                 payload_kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [TIME_W-1:0]    now_ms;
    } t_timer_req;

    // one result as it leaves the table
    typedef struct packed {
        logic [1:0]           kind;
        logic [1:0]           status;
        logic [TASK_W-1:0]    owner;
        logic [TIMER_W-1:0]   timer_id;
        logic                 payload_kind;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } t_timer_res;

    // shadow copy of the slot table and the results it predicts
    class timer_table_shadow;
        bit                   slot_used [SLOTS];
        bit                   slot_periodic [SLOTS];
        logic [TASK_W-1:0]    slot_owner [SLOTS];
        logic [TIMER_W-1:0]   slot_timer [SLOTS];
        logic [TIME_W-1:0]    slot_timeout [SLOTS];
        logic [TIME_W-1:0]    slot_start [SLOTS];
        logic                 slot_pkind [SLOTS];
        logic [PAYLOAD_W-1:0] slot_payload [SLOTS];
        t_timer_res           pending_results [$];
        int unsigned          mismatches;

        function new();
            mismatches = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void push_reply(logic [1:0] kind, logic [1:0] status, t_timer_req req);
            pending_results.push_back({kind, status, req.owner, req.timer_id, 1'b0,
                                       {PAYLOAD_W{1'b0}}, 1'b1});
        endfunction

        function int free_count();
            int n;
            n = 0;
            foreach (slot_used[i]) if (!slot_used[i]) n++;
            return n;
        endfunction

        // note an accepted request and predict what it gives
        function void apply_request(t_timer_req req);
            logic [TIME_W-1:0] limit;
            logic [TIME_W-1:0] elapsed;
            int hit;
            hit = -1;
            case (req.command)
                CMD_SET: begin
                    if (req.timer_id >= TIMER_IDS) begin
                        push_reply(RK_SET_REPLY, ST_BAD_ID, req);
                    end else begin
                        limit = req.timeout_ms;
                        if (limit == 0) limit = TIME_W'(MIN_TIMEOUT_MS);
                        if (limit > TIME_W'(MAX_TIMEOUT_MS)) limit = TIME_W'(MAX_TIMEOUT_MS);
                        for (int i = 0; i < SLOTS; i++)
                            if (hit < 0 && !slot_used[i]) hit = i;
                        if (hit < 0) begin
                            push_reply(RK_SET_REPLY, ST_FULL, req);
                        end else begin
                            slot_used[hit]     = 1'b1;
                            slot_periodic[hit] = req.periodic;
                            slot_owner[hit]    = req.owner;
                            slot_timer[hit]    = req.timer_id;
                            slot_timeout[hit]  = limit;
                            slot_start[hit]    = req.now_ms;
                            slot_pkind[hit]    = req.payload_kind;
                            slot_payload[hit]  = req.payload;
                            push_reply(RK_SET_REPLY, ST_OK, req);
                        end
                    end
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && slot_used[i] && slot_owner[i] == req.owner
                            && slot_timer[i] == req.timer_id)
                            hit = i;
                    if (hit < 0) begin
                        push_reply(RK_CLEAR_REPLY, ST_NOT_FOUND, req);
                    end else begin
                        slot_used[hit] = 1'b0;
                        push_reply(RK_CLEAR_REPLY, ST_OK, req);
                    end
                end
                CMD_CHECK: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        elapsed = req.now_ms - slot_start[i];
                        if (slot_used[i] && elapsed >= slot_timeout[i]) begin
                            pending_results.push_back({RK_EXPIRY, ST_OK, slot_owner[i],
                                                       slot_timer[i], slot_pkind[i],
                                                       slot_payload[i], 1'b0});
                            if (slot_periodic[i]) slot_start[i] = req.now_ms;
                            else slot_used[i] = 1'b0;
                        end
                    end
                    push_reply(RK_DONE, ST_OK, req);
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // compare an accepted result with the oldest prediction
        function void match_result(t_timer_res got);
            t_timer_res want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d status %0d", got.kind, got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            check_field("result_kind", 64'(want.kind), 64'(got.kind));
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("owner_task_res", 64'(want.owner), 64'(got.owner));
            check_field("timer_number_res", 64'(want.timer_id), 64'(got.timer_id));
            check_field("payload_kind_res", 64'(want.payload_kind), 64'(got.payload_kind));
            check_field("payload_value_res", 64'(want.payload), 64'(got.payload));
            check_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_valid;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_valid;
    logic                 m_ready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    timer_table_shadow shadow = new();
    logic [TIME_W-1:0] clock_ms;
    int                requests_sent;
    int                send_count;
    int                sender_odds;
    bit                calm_tail;

    software_timer_table #(
        .SLOTS     (SLOTS),
        .TIMER_IDS (TIMER_IDS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic t_timer_req make_req(logic [1:0] command, logic periodic,
                                            logic [15:0] owner, logic [15:0] timer_id,
                                            logic [31:0] timeout_ms, logic payload_kind,
                                            logic [31:0] payload, logic [31:0] now_ms);
        return {command, periodic, owner, timer_id, timeout_ms, payload_kind, payload, now_ms};
    endfunction

    function automatic logic [15:0] pick_owner();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 7));
    endfunction

    // present one request and hold it until the table takes it
    task automatic send_request(input t_timer_req req);
        int gap;
        send_count++;
        if (send_count % 30 == 0) begin
            case ($urandom_range(0, 2))
                0: sender_odds = 0;
                1: sender_odds = 2;
                default: sender_odds = 6;
            endcase
        end
        if (!calm_tail && sender_odds != 0 && $urandom_range(0, sender_odds) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        // tdata: periodic, owner_task, timer_number, timeout_ms, payload_value, now_ms
        s_tdata <= {7'd0, req.now_ms, req.payload, req.timeout_ms, req.timer_id,
                    req.owner, req.periodic};
        // tuser: command, payload_kind
        s_tuser <= {req.payload_kind, req.command};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        shadow.apply_request(req);
        if (req.command != CMD_NONE) requests_sent++;
    endtask

    // well-formed set with random content at the running clock
    task automatic issue_set();
        logic [31:0] timeout_ms;
        case ($urandom_range(0, 9))
            0: timeout_ms = 32'd0;
            1: timeout_ms = $urandom;
            2: timeout_ms = 32'd86400000 + $urandom_range(0, 2) - 1;
            default: timeout_ms = $urandom_range(10, 3000);
        endcase
        clock_ms += $urandom_range(0, 40);
        send_request(make_req(CMD_SET, 1'($urandom_range(0, 1)), pick_owner(),
                              16'($urandom_range(0, TIMER_IDS - 1)), timeout_ms,
                              1'($urandom_range(0, 1)), $urandom, clock_ms));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge clk);
    endtask

    // result side: random stall bursts, checks every accepted result
    initial begin : result_sink
        int         hold_left;
        int         odds;
        int         segment;
        t_timer_res got;
        hold_left = 0;
        odds      = 3;
        segment   = 0;
        m_ready  <= 1'b0;
        forever begin
            @(posedge clk);
            if (m_valid && m_ready) begin
                // tdata: status, owner_task_res, timer_number_res, payload_value_res
                got.status       = m_tdata[1:0];
                got.owner        = m_tdata[17:2];
                got.timer_id     = m_tdata[33:18];
                got.payload      = m_tdata[65:34];
                // tuser: result_kind, payload_kind_res
                got.kind         = m_tuser[1:0];
                got.payload_kind = m_tuser[2];
                got.last         = m_tlast;
                shadow.match_result(got);
            end
            segment++;
            if (segment == 60) begin
                segment = 0;
                odds = $urandom_range(0, 2) * 3;
            end
            if (hold_left > 0 && !calm_tail) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!calm_tail && odds != 0 && $urandom_range(0, odds * 4) == 0) begin
                hold_left = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ends the run when nothing moves for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("** software_timer_table: FAILED **");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int         pick;
        int         slot;
        t_timer_req req;
        logic [31:0] sweep_list [$];
        requests_sent = 0;
        send_count    = 0;
        sender_odds   = 3;
        calm_tail     = 1'b0;
        clock_ms      = 32'd1000;
        rst_n   <= 1'b0;
        s_valid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: clamping, bad ids, duplicates, clears, expiry edges, wrap
        send_request(make_req(CMD_SET, 1'b1, 16'hFFFF, 16'd31, 32'd0, 1'b1,
                              32'hFFFF_FFFF, 32'd1000));
        send_request(make_req(CMD_SET, 1'b0, 16'h0000, 16'd0, 32'hFFFF_FFFF, 1'b0,
                              32'h0, 32'd1000));
        send_request(make_req(CMD_SET, 1'b0, 16'd5, 16'd32, 32'd100, 1'b0, 32'd1, 32'd1000));
        send_request(make_req(CMD_SET, 1'b1, 16'd5, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(CMD_SET, 1'b0, 16'd5, 16'd3, 32'd86400001, 1'b0,
                              32'h1234_5678, 32'd1000));
        send_request(make_req(CMD_SET, 1'b0, 16'd5, 16'd3, 32'd86400000, 1'b1,
                              32'h8765_4321, 32'd1000));
        send_request(make_req(CMD_SET, 1'b0, 16'd5, 16'd3, 32'd500, 1'b1,
                              32'hA5A5_5A5A, 32'd1000));
        send_request(make_req(CMD_CHECK, 1'b0, 16'd9, 16'd9, 32'd0, 1'b0, 32'd0, 32'd1009));
        send_request(make_req(CMD_CHECK, 1'b0, 16'd9, 16'd9, 32'd0, 1'b0, 32'd0, 32'd1010));
        send_request(make_req(CMD_CLEAR, 1'b0, 16'd5, 16'd3, 32'd0, 1'b0, 32'd0, 32'd1010));
        send_request(make_req(CMD_CLEAR, 1'b0, 16'd5, 16'd3, 32'd0, 1'b0, 32'd0, 32'd1010));
        send_request(make_req(CMD_CLEAR, 1'b0, 16'd6, 16'd3, 32'd0, 1'b0, 32'd0, 32'd1010));
        send_request(make_req(CMD_NONE, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(CMD_CHECK, 1'b0, 16'd0, 16'd0, 32'd0, 1'b0, 32'd0, 32'd1500));
        send_request(make_req(CMD_SET, 1'b0, 16'd7, 16'd1, 32'd100, 1'b0,
                              32'h0000_00FF, 32'hFFFF_FFF0));
        send_request(make_req(CMD_CHECK, 1'b0, 16'd7, 16'd1, 32'd0, 1'b0, 32'd0, 32'h50));
        send_request(make_req(CMD_CHECK, 1'b0, 16'd7, 16'd1, 32'd0, 1'b0, 32'd0, 32'h54));
        send_request(make_req(CMD_CLEAR, 1'b0, 16'hFFFF, 16'd31, 32'd0, 1'b0, 32'd0, 32'h54));
        send_request(make_req(CMD_CLEAR, 1'b0, 16'd7, 16'hFFFF, 32'd0, 1'b0, 32'd0, 32'h54));
        send_request(make_req(CMD_CHECK, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                              32'hFFFF_FFFF, 32'h54));

        // hold off until the table has answered everything so far
        wait_for_results();
        clock_ms = $urandom;

        // random mix of set, clear and check sequences, with noise
        while (requests_sent < REQUEST_TARGET) begin
            calm_tail = (requests_sent >= REQUEST_TARGET - CALM_TAIL);
            if ($urandom_range(0, 39) == 0)
                clock_ms = $urandom_range(0, 1) ? $urandom
                                                : 32'hFFFF_F000 + $urandom_range(0, 4095);
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                issue_set();
            end else if (pick < 63) begin
                clock_ms += $urandom_range(0, 2500);
                send_request(make_req(CMD_CHECK, 1'($urandom_range(0, 1)), 16'($urandom),
                                      16'($urandom), $urandom, 1'($urandom_range(0, 1)),
                                      $urandom, clock_ms));
            end else if (pick < 78) begin
                // clear a live timer most of the time, else a likely miss
                slot = -1;
                if ($urandom_range(0, 3) != 0 && shadow.free_count() != SLOTS) begin
                    slot = $urandom_range(0, SLOTS - 1);
                    while (!shadow.slot_used[slot]) slot = (slot + 1) % SLOTS;
                end
                if (slot >= 0)
                    send_request(make_req(CMD_CLEAR, 1'($urandom_range(0, 1)),
                                          shadow.slot_owner[slot], shadow.slot_timer[slot],
                                          $urandom, 1'($urandom_range(0, 1)), $urandom,
                                          clock_ms));
                else
                    send_request(make_req(CMD_CLEAR, 1'b0, pick_owner(),
                                          16'($urandom_range(0, TIMER_IDS - 1)), $urandom,
                                          1'b0, $urandom, clock_ms));
            end else if (pick < 88) begin
                req = make_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               16'($urandom), 16'($urandom), $urandom,
                               1'($urandom_range(0, 1)), $urandom, $urandom);
                send_request(req);
            end else if (pick < 92) begin
                // fill the table and one set beyond it
                while (shadow.free_count() != 0) issue_set();
                issue_set();
            end else if (pick < 96) begin
                // clear every live timer
                sweep_list.delete();
                foreach (shadow.slot_used[i])
                    if (shadow.slot_used[i])
                        sweep_list.push_back({shadow.slot_owner[i], shadow.slot_timer[i]});
                foreach (sweep_list[i])
                    send_request(make_req(CMD_CLEAR, 1'b0, sweep_list[i][31:16],
                                          sweep_list[i][15:0], 32'd0, 1'b0, 32'd0, clock_ms));
            end else begin
                wait_for_results();
            end
        end

        // drain and let any late output show itself
        calm_tail = 1'b1;
        wait_for_results();
        repeat (2 * SLOTS + 8) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
            $display("** software_timer_table: PASSED **");
        end else begin
            $display("** software_timer_table: FAILED **");
        end
        $finish;
    end

endmodule
